// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the datapath RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SMC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define SMC_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// ===== rtl/smc_pkg.sv =====
// Shared types, codes and constants of the microcoded datapath.
// Depends on nothing.
`default_nettype none
package smc_pkg;

   localparam int MEM_BYTES_DEF = 65536;
   localparam int CS_DEPTH_DEF  = 512;
   localparam int MI_W          = 36;

   // action codes
   localparam logic [1:0] ACT_STEP = 2'd0;
   localparam logic [1:0] ACT_LDCS = 2'd1;
   localparam logic [1:0] ACT_LDMEM = 2'd2;
   localparam logic [1:0] ACT_READ = 2'd3;

   // B bus sources
   localparam logic [3:0] B_MDR  = 4'd0;
   localparam logic [3:0] B_PC   = 4'd1;
   localparam logic [3:0] B_MBR  = 4'd2;
   localparam logic [3:0] B_MBRU = 4'd3;
   localparam logic [3:0] B_SP   = 4'd4;
   localparam logic [3:0] B_LV   = 4'd5;
   localparam logic [3:0] B_CPP  = 4'd6;
   localparam logic [3:0] B_TOS  = 4'd7;
   localparam logic [3:0] B_OPC  = 4'd8;

   // ALU functions
   localparam logic [5:0] F_A      = 6'h18;
   localparam logic [5:0] F_B      = 6'h14;
   localparam logic [5:0] F_NOTA   = 6'h1A;
   localparam logic [5:0] F_NOTB   = 6'h2C;
   localparam logic [5:0] F_ADD    = 6'h3C;
   localparam logic [5:0] F_ADDC   = 6'h3D;
   localparam logic [5:0] F_INCA   = 6'h39;
   localparam logic [5:0] F_INCB   = 6'h35;
   localparam logic [5:0] F_SUB    = 6'h3F;
   localparam logic [5:0] F_DECB   = 6'h36;
   localparam logic [5:0] F_NEGA   = 6'h3B;
   localparam logic [5:0] F_AND    = 6'h0C;
   localparam logic [5:0] F_OR     = 6'h1C;
   localparam logic [5:0] F_ZERO   = 6'h10;
   localparam logic [5:0] F_ONE    = 6'h31;
   localparam logic [5:0] F_ONES   = 6'h32;

   // shifter codes
   localparam logic [1:0] SH_SLL8 = 2'd1;
   localparam logic [1:0] SH_SRA1 = 2'd2;

   typedef struct packed {
      logic [31:0] mdr;
      logic [31:0] pc;
      logic [31:0] sp;
      logic [31:0] lv;
      logic [31:0] cpp;
      logic [31:0] tos;
      logic [31:0] opc;
      logic [31:0] h;
      logic [7:0]  mbr;
      logic [31:0] alu_hold;
      logic [31:0] b_hold;
   } exec_src_type;

   typedef struct packed {
      logic [31:0] b_bus;
      logic [31:0] alu_out;
      logic [31:0] c_bus;
   } exec_res_type;

   function automatic logic [31:0] alu_fn(input logic [5:0] f, input logic [31:0] a,
                                          input logic [31:0] b, input logic [31:0] hold);
      logic [31:0] r;
      case (f)
         F_A:    r = a;
         F_B:    r = b;
         F_NOTA: r = ~a;
         F_NOTB: r = ~b;
         F_ADD:  r = a + b;
         F_ADDC: r = a + b + 32'd1;
         F_INCA: r = a + 32'd1;
         F_INCB: r = b + 32'd1;
         F_SUB:  r = b - a;
         F_DECB: r = b - 32'd1;
         F_NEGA: r = 32'd0 - a;
         F_AND:  r = a & b;
         F_OR:   r = a | b;
         F_ZERO: r = 32'd0;
         F_ONE:  r = 32'd1;
         F_ONES: r = 32'hFFFF_FFFF;
         default: r = hold;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/smc_ifs.sv =====
// Valid/ready channel interfaces for step/load items and result items.
// Depends on nothing.
`default_nettype none
interface smc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] address;
   logic [35:0] load_value;
   modport source (output valid, action, address, load_value, input ready);
   modport sink (input valid, action, address, load_value, output ready);
endinterface

interface smc_rsp_if;
   logic        valid;
   logic        ready;
   logic [8:0]  micro_pc;
   logic [31:0] prog_counter;
   logic [31:0] stack_ptr;
   logic [31:0] top_of_stack;
   logic [31:0] mem_data_reg;
   logic [31:0] mem_addr_reg;
   logic [31:0] holding_reg;
   logic [7:0]  fetched_byte;
   logic        neg_flag;
   logic        zero_flag;
   logic [7:0]  read_byte;
   modport source (output valid, micro_pc, prog_counter, stack_ptr, top_of_stack,
                   mem_data_reg, mem_addr_reg, holding_reg, fetched_byte, neg_flag,
                   zero_flag, read_byte, input ready);
   modport sink (input valid, micro_pc, prog_counter, stack_ptr, top_of_stack,
                 mem_data_reg, mem_addr_reg, holding_reg, fetched_byte, neg_flag,
                 zero_flag, read_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/stack_machine_microcode_datapath_core.sv =====
// Top level of the microcoded stack machine datapath: sequencer, registers, memories.
// Depends on smc_pkg, smc_ifs, smc_ram, smc_exec and assert_macros.svh.
//
//  channel   dir  handshake      item
//  req_chan  in   valid/ready    action, address, load_value
//  rsp_chan  out  valid/ready    micro_pc, registers, flags, read_byte
//
// A step runs S_EXEC, then a fetch, word read and word write as its memory bits
// ask, then S_FIN; words move byte by byte through the single byte-wide port of
// main memory. Loads go straight to S_FIN, a byte read through S_RB. One item is
// buffered at the input; req_chan.ready is high while it is empty, so a next item
// can wait while one is at work. S_FIN waits for a free result register. Reset is
// synchronous; the memories are not cleared. MEM_BYTES must be a power of two.
`default_nettype none
`include "assert_macros.svh"
module stack_machine_microcode_datapath_core
   import smc_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEF,
   parameter int CS_DEPTH  = CS_DEPTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   smc_req_if.sink   req_chan,
   smc_rsp_if.source rsp_chan
);
   localparam int MW = $clog2(MEM_BYTES);
   localparam int CW = $clog2(CS_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_FE, S_FEC, S_RD, S_WR, S_RB, S_FIN
   } state_type;

   state_type   state_ff;
   logic [2:0]  cnt_ff;

   // input buffer
   logic        buf_valid_ff;
   logic [1:0]  buf_action_ff;
   logic [15:0] buf_address_ff;
   logic [35:0] buf_value_ff;

   // architectural registers
   logic [8:0]  upc_ff;
   logic [31:0] mar_ff, mdr_ff, pc_ff, sp_ff, lv_ff, cpp_ff, tos_ff, opc_ff, h_ff;
   logic [7:0]  mbr_ff;
   logic        n_ff, z_ff;
   logic [31:0] alu_hold_ff, b_hold_ff;

   // per-item scratch
   logic [8:0]  nadd_ff;
   logic [2:0]  jam_ff;
   logic [2:0]  memop_ff;
   logic        is_step_ff;
   logic [7:0]  rb_ff;

   // result register
   logic        rsp_valid_ff;

   // memory ports
   logic            cs_en, cs_we;
   logic [CW-1:0]   cs_addr;
   logic [MI_W-1:0] cs_rdata;
   logic            mm_en, mm_we;
   logic [MW-1:0]   mm_addr;
   logic [7:0]      mm_wdata, mm_rdata;

   exec_src_type src;
   exec_res_type res;

   logic [31:0] in_addr32;
   logic [31:0] byte_addr32;
   logic [31:0] pc32;
   logic [8:0]  upc_in;
   logic        rsp_free;
   logic        take_item;

   assign in_addr32   = {16'd0, buf_address_ff};
   assign byte_addr32 = {mar_ff[29:0], cnt_ff[1:0]};
   assign pc32        = pc_ff;
   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;
   assign take_item   = (state_ff == S_IDLE) && buf_valid_ff;
   assign req_chan.ready = !buf_valid_ff;

   smc_ram #(.WIDTH(MI_W), .DEPTH(CS_DEPTH)) u_cstore (
      .clock(clock), .en(cs_en), .we(cs_we), .addr(cs_addr),
      .wdata(buf_value_ff), .rdata(cs_rdata)
   );

   smc_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock(clock), .en(mm_en), .we(mm_we), .addr(mm_addr),
      .wdata(mm_wdata), .rdata(mm_rdata)
   );

   assign src = '{mdr: mdr_ff, pc: pc_ff, sp: sp_ff, lv: lv_ff, cpp: cpp_ff,
                  tos: tos_ff, opc: opc_ff, h: h_ff, mbr: mbr_ff,
                  alu_hold: alu_hold_ff, b_hold: b_hold_ff};

   smc_exec u_exec (.mi(cs_rdata), .src(src), .res(res));

   // memory port steering
   always_comb begin
      cs_en    = 1'b0;
      cs_we    = 1'b0;
      cs_addr  = upc_ff[CW-1:0];
      mm_en    = 1'b0;
      mm_we    = 1'b0;
      mm_addr  = byte_addr32[MW-1:0];
      mm_wdata = 8'd0;
      case (state_ff)
         S_IDLE: begin
            if (buf_valid_ff) begin
               case (buf_action_ff)
                  ACT_STEP: cs_en = 1'b1;
                  ACT_LDCS: begin
                     cs_en   = 1'b1;
                     cs_we   = 1'b1;
                     cs_addr = in_addr32[CW-1:0];
                  end
                  ACT_LDMEM: begin
                     mm_en   = 1'b1;
                     mm_we   = 1'b1;
                     mm_addr = in_addr32[MW-1:0];
                     mm_wdata = buf_value_ff[7:0];
                  end
                  default: begin
                     mm_en   = 1'b1;
                     mm_addr = in_addr32[MW-1:0];
                  end
               endcase
            end
         end
         S_FE: begin
            mm_en   = 1'b1;
            mm_addr = pc32[MW-1:0];
         end
         S_RD: begin
            mm_en = !cnt_ff[2];
         end
         S_WR: begin
            mm_en = 1'b1;
            mm_we = 1'b1;
            case (cnt_ff[1:0])
               2'd0: mm_wdata = mdr_ff[7:0];
               2'd1: mm_wdata = mdr_ff[15:8];
               2'd2: mm_wdata = mdr_ff[23:16];
               default: mm_wdata = mdr_ff[31:24];
            endcase
         end
         default: ;
      endcase
   end

   // next microaddress: OR in the jam bits and, on JMPC, the MBR
   always_comb begin
      upc_in = upc_ff;
      if (is_step_ff) begin
         upc_in[8]   = nadd_ff[8] | (jam_ff[1] & n_ff) | (jam_ff[0] & z_ff);
         upc_in[7:0] = nadd_ff[7:0] | (jam_ff[2] ? mbr_ff : 8'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= 3'd0;
         buf_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         upc_ff       <= 9'd0;
         mar_ff <= '0; mdr_ff <= '0; pc_ff <= '0; sp_ff <= '0; lv_ff <= '0;
         cpp_ff <= '0; tos_ff <= '0; opc_ff <= '0; h_ff <= '0;
         mbr_ff       <= 8'd0;
         n_ff         <= 1'b0;
         z_ff         <= 1'b1;
         alu_hold_ff  <= '0;
         b_hold_ff    <= '0;
         is_step_ff   <= 1'b0;
      end else begin
         // accept into the buffer
         if (req_chan.valid && req_chan.ready) begin
            buf_valid_ff   <= 1'b1;
            buf_action_ff  <= req_chan.action;
            buf_address_ff <= req_chan.address;
            buf_value_ff   <= req_chan.load_value;
         end
         // drop the result once taken; S_FIN reloads the register itself
         if (rsp_valid_ff && rsp_chan.ready && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (take_item) begin
                  buf_valid_ff <= 1'b0;
                  is_step_ff   <= (buf_action_ff == ACT_STEP);
                  rb_ff        <= 8'd0;
                  case (buf_action_ff)
                     ACT_STEP: state_ff <= S_EXEC;
                     ACT_READ: state_ff <= S_RB;
                     default:  state_ff <= S_FIN;
                  endcase
               end
            end
            S_EXEC: begin
               b_hold_ff   <= res.b_bus;
               alu_hold_ff <= res.alu_out;
               n_ff        <= res.alu_out[31];
               z_ff        <= (res.alu_out == 32'd0);
               if (cs_rdata[15]) h_ff   <= res.c_bus;
               if (cs_rdata[14]) opc_ff <= res.c_bus;
               if (cs_rdata[13]) tos_ff <= res.c_bus;
               if (cs_rdata[12]) cpp_ff <= res.c_bus;
               if (cs_rdata[11]) lv_ff  <= res.c_bus;
               if (cs_rdata[10]) sp_ff  <= res.c_bus;
               if (cs_rdata[9])  pc_ff  <= res.c_bus;
               if (cs_rdata[8])  mdr_ff <= res.c_bus;
               if (cs_rdata[7])  mar_ff <= res.c_bus;
               nadd_ff  <= cs_rdata[35:27];
               jam_ff   <= cs_rdata[26:24];
               memop_ff <= cs_rdata[6:4];
               cnt_ff   <= 3'd0;
               if (cs_rdata[4]) begin
                  state_ff <= S_FE;
               end else if (cs_rdata[5]) begin
                  state_ff <= S_RD;
               end else if (cs_rdata[6]) begin
                  state_ff <= S_WR;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_FE: state_ff <= S_FEC;
            S_FEC: begin
               mbr_ff <= mm_rdata;
               if (memop_ff[1]) begin
                  state_ff <= S_RD;
               end else if (memop_ff[2]) begin
                  state_ff <= S_WR;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_RD: begin
               // issue byte cnt, capture byte cnt-1
               case (cnt_ff)
                  3'd1: mdr_ff[7:0]   <= mm_rdata;
                  3'd2: mdr_ff[15:8]  <= mm_rdata;
                  3'd3: mdr_ff[23:16] <= mm_rdata;
                  3'd4: mdr_ff[31:24] <= mm_rdata;
                  default: ;
               endcase
               if (cnt_ff[2]) begin
                  cnt_ff   <= 3'd0;
                  state_ff <= memop_ff[2] ? S_WR : S_FIN;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_WR: begin
               if (cnt_ff[1:0] == 2'd3) begin
                  cnt_ff   <= 3'd0;
                  state_ff <= S_FIN;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_RB: begin
               rb_ff    <= mm_rdata;
               state_ff <= S_FIN;
            end
            S_FIN: begin
               // hold until the result register is free
               if (rsp_free) begin
                  upc_ff       <= upc_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // result payload, loaded together with rsp_valid_ff
   always_ff @(posedge clock) begin
      if (state_ff == S_FIN && rsp_free) begin
         rsp_chan.micro_pc     <= upc_in;
         rsp_chan.prog_counter <= pc_ff;
         rsp_chan.stack_ptr    <= sp_ff;
         rsp_chan.top_of_stack <= tos_ff;
         rsp_chan.mem_data_reg <= mdr_ff;
         rsp_chan.mem_addr_reg <= mar_ff;
         rsp_chan.holding_reg  <= h_ff;
         rsp_chan.fetched_byte <= mbr_ff;
         rsp_chan.neg_flag     <= n_ff;
         rsp_chan.zero_flag    <= z_ff;
         rsp_chan.read_byte    <= rb_ff;
      end
   end
   assign rsp_chan.valid = rsp_valid_ff;

   `SMC_ASSERT(a_take_leaves_idle, clock, reset,
      (state_ff == S_IDLE && buf_valid_ff) |=> (state_ff != S_IDLE))
   `SMC_ASSERT(a_fin_waits_for_sink, clock, reset,
      (state_ff == S_FIN && rsp_valid_ff && !rsp_chan.ready) |=> (state_ff == S_FIN))
   `SMC_NEVER(a_mem_write_place, clock, reset,
      mm_we && state_ff != S_WR && state_ff != S_IDLE)
endmodule
`default_nettype wire

// ===== rtl/smc_ram.sv =====
// Single-port synchronous RAM with registered read.
// Depends on nothing.
`default_nettype none
module smc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end
endmodule
`default_nettype wire

// ===== rtl/smc_exec.sv =====
// B bus select, ALU and shifter for one microinstruction.
// Depends on smc_pkg.
`default_nettype none
module smc_exec
   import smc_pkg::*;
(
   input  wire logic [MI_W-1:0] mi,
   input  wire exec_src_type    src,
   output exec_res_type         res
);
   logic [31:0] b_bus;
   logic [31:0] alu_out;

   always_comb begin
      case (mi[3:0])
         B_MDR:  b_bus = src.mdr;
         B_PC:   b_bus = src.pc;
         B_MBR:  b_bus = {{24{src.mbr[7]}}, src.mbr};
         B_MBRU: b_bus = {24'd0, src.mbr};
         B_SP:   b_bus = src.sp;
         B_LV:   b_bus = src.lv;
         B_CPP:  b_bus = src.cpp;
         B_TOS:  b_bus = src.tos;
         B_OPC:  b_bus = src.opc;
         default: b_bus = src.b_hold;
      endcase
      alu_out = alu_fn(mi[21:16], src.h, b_bus, src.alu_hold);
      res.b_bus = b_bus;
      res.alu_out = alu_out;
      case (mi[23:22])
         SH_SLL8: res.c_bus = {alu_out[23:0], 8'd0};
         SH_SRA1: res.c_bus = {alu_out[31], alu_out[31:1]};
         default: res.c_bus = alu_out;
      endcase
   end
endmodule
`default_nettype wire

// ===== tb/sv/stack_machine_microcode_datapath_core_tb.sv =====
// Self-checking testbench for the microcoded stack machine datapath core.
// Depends on smc_pkg, smc_ifs and stack_machine_microcode_datapath_core.
`timescale 1ns / 1ps
module stack_machine_microcode_datapath_core_tb;
   import smc_pkg::*;

   // word register indexes, in C-mask bit order
   localparam int REG_MAR = 0;
   localparam int REG_MDR = 1;
   localparam int REG_PC  = 2;
   localparam int REG_SP  = 3;
   localparam int REG_LV  = 4;
   localparam int REG_CPP = 5;
   localparam int REG_TOS = 6;
   localparam int REG_OPC = 7;
   localparam int REG_H   = 8;

   // memory command bits and jump bits of a microinstruction
   localparam logic [2:0] MEM_FETCH = 3'b001;
   localparam logic [2:0] MEM_RD    = 3'b010;
   localparam logic [2:0] MEM_WR    = 3'b100;
   localparam logic [2:0] JAM_Z     = 3'b001;
   localparam logic [2:0] JAM_N     = 3'b010;
   localparam logic [2:0] JMP_C     = 3'b100;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int ITEM_TARGET = 1450;

   localparam logic [5:0] ALU_CODES [16] = '{F_A, F_B, F_NOTA, F_NOTB, F_ADD, F_ADDC,
      F_INCA, F_INCB, F_SUB, F_DECB, F_NEGA, F_AND, F_OR, F_ZERO, F_ONE, F_ONES};

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] address;
      logic [35:0] load_value;
   } req_item_t;

   typedef struct packed {
      logic [8:0]  micro_pc;
      logic [31:0] prog_counter;
      logic [31:0] stack_ptr;
      logic [31:0] top_of_stack;
      logic [31:0] mem_data_reg;
      logic [31:0] mem_addr_reg;
      logic [31:0] holding_reg;
      logic [7:0]  fetched_byte;
      logic        neg_flag;
      logic        zero_flag;
      logic [7:0]  read_byte;
   } dp_state_t;

   logic clock;
   logic reset;

   smc_req_if req_if ();
   smc_rsp_if rsp_if ();

   stack_machine_microcode_datapath_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   // Datapath shadow: control store and memory plus written-flags, so that the
   // stimulus never touches a location that holds nothing yet.
   logic [35:0] cs_word [512];
   bit          cs_written [512];
   logic [7:0]  mem_byte [65536];
   bit          mem_written [65536];
   logic [31:0] wreg [9];
   logic [8:0]  upc_q;
   logic [7:0]  mbr_q;
   logic        n_q, z_q;
   logic [31:0] alu_last, b_last;

   req_item_t pending_items [$];
   dp_state_t expected_states [$];

   int n_steps, n_cs_loads, n_mem_loads, n_reads;
   int failures;
   int cycle_count;
   bit quiet_send, quiet_recv;
   int send_gap, recv_gap;
   int sent_count, recv_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [35:0] micro_word(logic [8:0] nxt, logic [2:0] jam,
                                              logic [1:0] sft, logic [5:0] fn,
                                              logic [8:0] cmask, logic [2:0] mem,
                                              logic [3:0] bsel);
      return {nxt, jam, sft, fn, cmask, mem, bsel};
   endfunction

   function automatic logic [31:0] b_bus_value(logic [3:0] bsel);
      case (bsel)
         B_MDR:  return wreg[REG_MDR];
         B_PC:   return wreg[REG_PC];
         B_MBR:  return mbr_q[7] ? {24'hFFFFFF, mbr_q} : {24'h0, mbr_q};
         B_MBRU: return {24'h0, mbr_q};
         B_SP:   return wreg[REG_SP];
         B_LV:   return wreg[REG_LV];
         B_CPP:  return wreg[REG_CPP];
         B_TOS:  return wreg[REG_TOS];
         B_OPC:  return wreg[REG_OPC];
         default: return b_last;
      endcase
   endfunction

   function automatic logic [31:0] alu_value(logic [5:0] fn, logic [31:0] a, logic [31:0] b);
      case (fn)
         F_A:    return a;
         F_B:    return b;
         F_NOTA: return ~a;
         F_NOTB: return ~b;
         F_ADD:  return a + b;
         F_ADDC: return a + b + 32'd1;
         F_INCA: return a + 32'd1;
         F_INCB: return b + 32'd1;
         F_SUB:  return b - a;
         F_DECB: return b - 32'd1;
         F_NEGA: return 32'd0 - a;
         F_AND:  return a & b;
         F_OR:   return a | b;
         F_ZERO: return 32'd0;
         F_ONE:  return 32'd1;
         F_ONES: return 32'hFFFF_FFFF;
         default: return alu_last;
      endcase
   endfunction

   function automatic logic [31:0] shift_value(logic [1:0] sft, logic [31:0] v);
      if (sft == SH_SLL8) return v << 8;
      if (sft == SH_SRA1) return {v[31], v[31:1]};
      return v;
   endfunction

   // Apply one item to the shadow state and queue it with the state it leads to.
   task automatic issue_item(logic [1:0] act, logic [15:0] addr, logic [35:0] val);
      req_item_t  it;
      dp_state_t  exp_s;
      logic [35:0] mi;
      logic [31:0] bv, cv, base;
      logic [8:0]  nxt;
      logic [7:0]  rb;
      rb = 8'h00;
      case (act)
         ACT_STEP: begin
            mi = cs_word[upc_q];
            bv = b_bus_value(mi[3:0]);
            b_last = bv;
            alu_last = alu_value(mi[21:16], wreg[REG_H], bv);
            n_q = alu_last[31];
            z_q = (alu_last == 32'd0);
            cv = shift_value(mi[23:22], alu_last);
            for (int i = 0; i < 9; i++)
               if (mi[7 + i]) wreg[i] = cv;
            // memory works in fetch, read, write order
            if (mi[4]) mbr_q = mem_byte[wreg[REG_PC][15:0]];
            base = wreg[REG_MAR] << 2;
            if (mi[5])
               for (int i = 0; i < 4; i++)
                  wreg[REG_MDR][8*i +: 8] = mem_byte[16'(base + i)];
            if (mi[6])
               for (int i = 0; i < 4; i++) begin
                  mem_byte[16'(base + i)] = wreg[REG_MDR][8*i +: 8];
                  mem_written[16'(base + i)] = 1'b1;
               end
            nxt = mi[35:27];
            if ((mi[25] && n_q) || (mi[24] && z_q)) nxt[8] = 1'b1;
            if (mi[26]) nxt[7:0] = nxt[7:0] | mbr_q;
            upc_q = nxt;
            n_steps++;
         end
         ACT_LDCS: begin
            cs_word[addr[8:0]] = val;
            cs_written[addr[8:0]] = 1'b1;
            n_cs_loads++;
         end
         ACT_LDMEM: begin
            mem_byte[addr] = val[7:0];
            mem_written[addr] = 1'b1;
            n_mem_loads++;
         end
         default: begin
            rb = mem_byte[addr];
            n_reads++;
         end
      endcase
      it.action = act;
      it.address = addr;
      it.load_value = val;
      pending_items.push_back(it);
      exp_s.micro_pc = upc_q;
      exp_s.prog_counter = wreg[REG_PC];
      exp_s.stack_ptr = wreg[REG_SP];
      exp_s.top_of_stack = wreg[REG_TOS];
      exp_s.mem_data_reg = wreg[REG_MDR];
      exp_s.mem_addr_reg = wreg[REG_MAR];
      exp_s.holding_reg = wreg[REG_H];
      exp_s.fetched_byte = mbr_q;
      exp_s.neg_flag = n_q;
      exp_s.zero_flag = z_q;
      exp_s.read_byte = rb;
      expected_states.push_back(exp_s);
   endtask

   task automatic fill_byte(logic [15:0] addr);
      if (!mem_written[addr])
         issue_item(ACT_LDMEM, addr, 36'({$urandom(), $urandom()}));
   endtask

   // Fill whatever the next step would read, then run it.
   task automatic run_step();
      logic [35:0] mi;
      logic [31:0] cv, mar_n, pc_n;
      if (!cs_written[upc_q])
         issue_item(ACT_LDCS, 16'(upc_q), 36'({$urandom(), $urandom()}));
      mi = cs_word[upc_q];
      cv = shift_value(mi[23:22],
                       alu_value(mi[21:16], wreg[REG_H], b_bus_value(mi[3:0])));
      mar_n = mi[7 + REG_MAR] ? cv : wreg[REG_MAR];
      pc_n = mi[7 + REG_PC] ? cv : wreg[REG_PC];
      if (mi[4]) fill_byte(pc_n[15:0]);
      if (mi[5])
         for (int i = 0; i < 4; i++) fill_byte(16'((mar_n << 2) + i));
      issue_item(ACT_STEP, 16'h0000, 36'h0);
   endtask

   // Place a word at the current microaddress and execute it.
   task automatic exec_word(logic [35:0] mi);
      issue_item(ACT_LDCS, {7'($urandom_range(0, 127)), upc_q}, mi);
      run_step();
   endtask

   function automatic logic [35:0] random_word();
      logic [5:0] fn;
      logic [3:0] bsel;
      fn = ($urandom_range(0, 9) != 0) ? ALU_CODES[$urandom_range(0, 15)] : 6'($urandom());
      bsel = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, 8)) : 4'($urandom());
      return micro_word(9'($urandom()), 3'($urandom()), 2'($urandom()), fn,
                        9'($urandom()), 3'($urandom()), bsel);
   endfunction

   task automatic build_stimulus();
      logic [15:0] a;
      // directed: byte extremes, top of memory, each shifter mode, odd codes
      issue_item(ACT_LDMEM, 16'h0000, 36'h0_0000_0080);
      issue_item(ACT_LDMEM, 16'h0001, 36'h0_0000_0001);
      issue_item(ACT_LDMEM, 16'h0002, 36'hF_FFFF_FFFF);
      issue_item(ACT_LDMEM, 16'h0003, 36'h0_0000_007F);
      issue_item(ACT_LDMEM, 16'hFFFF, 36'hA_5A5A_5AA5);
      issue_item(ACT_READ, 16'hFFFF, 36'h0);
      exec_word(micro_word(9'd1, 3'd0, 2'd0, F_ONES, 9'h100, 3'd0, B_MDR));
      exec_word(micro_word(9'd2, 3'd0, 2'd0, F_ZERO, 9'h005, MEM_FETCH | MEM_RD, B_MDR));
      exec_word(micro_word(9'd3, 3'd0, SH_SRA1, F_B, 9'h100, 3'd0, B_MBR));
      exec_word(micro_word(9'd4, 3'd0, SH_SLL8, F_ADD, 9'h048, MEM_WR, B_MBRU));
      exec_word(micro_word(9'd5, JAM_N | JAM_Z, 2'd3, 6'h00, 9'h080, 3'd0, 4'hF));
      exec_word(micro_word(9'h1FF, JMP_C, 2'd0, F_NEGA, 9'h1FF, MEM_FETCH, B_OPC));
      issue_item(ACT_READ, 16'h0002, 36'h0);
      // random part: mostly fresh microwords at the current address
      while (pending_items.size() < ITEM_TARGET) begin
         case ($urandom_range(0, 19))
            0, 1: issue_item(ACT_LDMEM, 16'($urandom()), 36'({$urandom(), $urandom()}));
            2: issue_item(ACT_LDCS, 16'($urandom()), 36'({$urandom(), $urandom()}));
            3: begin
               a = 16'($urandom());
               fill_byte(a);
               issue_item(ACT_READ, a, 36'({$urandom(), $urandom()}));
            end
            4, 5, 6, 7: run_step();
            default: exec_word(random_word());
         endcase
      end
   endtask

   // Driver: hold an item until accepted, then advance to the next or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) sent_count++;
         if (send_gap > 0) begin
            req_if.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_items.size() > 0) begin
            req_item_t it;
            it = pending_items.pop_front();
            req_if.action <= it.action;
            req_if.address <= it.address;
            req_if.load_value <= it.load_value;
            req_if.valid <= 1'b1;
            if ($urandom_range(0, 199) == 0) quiet_send = ~quiet_send;
            if (quiet_send || $urandom_range(0, 2) != 0) send_gap <= 0;
            else if ($urandom_range(0, 9) != 0) send_gap <= $urandom_range(1, 3);
            else send_gap <= $urandom_range(5, 30);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result side: random stalls on ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_gap <= 0;
      end else if (recv_gap > 0) begin
         rsp_if.ready <= 1'b0;
         recv_gap <= recv_gap - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if ($urandom_range(0, 199) == 0) quiet_recv = ~quiet_recv;
         if (!quiet_recv && $urandom_range(0, 3) == 0)
            recv_gap <= ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3)
                                                    : $urandom_range(5, 30);
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         recv_count++;
         if (expected_states.size() == 0) begin
            $error("result item with nothing expected, micro_pc %0h", rsp_if.micro_pc);
            failures++;
         end else begin
            dp_state_t e;
            e = expected_states.pop_front();
            if (rsp_if.micro_pc !== e.micro_pc) begin
               $error("micro_pc exp %0h got %0h", e.micro_pc, rsp_if.micro_pc);
               failures++;
            end
            if (rsp_if.prog_counter !== e.prog_counter) begin
               $error("prog_counter exp %0h got %0h", e.prog_counter, rsp_if.prog_counter);
               failures++;
            end
            if (rsp_if.stack_ptr !== e.stack_ptr) begin
               $error("stack_ptr exp %0h got %0h", e.stack_ptr, rsp_if.stack_ptr);
               failures++;
            end
            if (rsp_if.top_of_stack !== e.top_of_stack) begin
               $error("top_of_stack exp %0h got %0h", e.top_of_stack, rsp_if.top_of_stack);
               failures++;
            end
            if (rsp_if.mem_data_reg !== e.mem_data_reg) begin
               $error("mem_data_reg exp %0h got %0h", e.mem_data_reg, rsp_if.mem_data_reg);
               failures++;
            end
            if (rsp_if.mem_addr_reg !== e.mem_addr_reg) begin
               $error("mem_addr_reg exp %0h got %0h", e.mem_addr_reg, rsp_if.mem_addr_reg);
               failures++;
            end
            if (rsp_if.holding_reg !== e.holding_reg) begin
               $error("holding_reg exp %0h got %0h", e.holding_reg, rsp_if.holding_reg);
               failures++;
            end
            if (rsp_if.fetched_byte !== e.fetched_byte) begin
               $error("fetched_byte exp %0h got %0h", e.fetched_byte, rsp_if.fetched_byte);
               failures++;
            end
            if (rsp_if.neg_flag !== e.neg_flag) begin
               $error("neg_flag exp %0b got %0b", e.neg_flag, rsp_if.neg_flag);
               failures++;
            end
            if (rsp_if.zero_flag !== e.zero_flag) begin
               $error("zero_flag exp %0b got %0b", e.zero_flag, rsp_if.zero_flag);
               failures++;
            end
            if (rsp_if.read_byte !== e.read_byte) begin
               $error("read_byte exp %0h got %0h", e.read_byte, rsp_if.read_byte);
               failures++;
            end
         end
      end
   end

   // Watchdog: drop the run if it stalls.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due",
                  cycle_count, expected_states.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.action = ACT_STEP;
      req_if.address = 16'h0;
      req_if.load_value = 36'h0;
      rsp_if.ready = 1'b0;
      quiet_send = 1'b0;
      quiet_recv = 1'b0;
      failures = 0;
      cycle_count = 0;
      sent_count = 0;
      recv_count = 0;
      n_steps = 0;
      n_cs_loads = 0;
      n_mem_loads = 0;
      n_reads = 0;
      // reset state of the datapath shadow
      for (int i = 0; i < 512; i++) cs_written[i] = 1'b0;
      for (int i = 0; i < 65536; i++) mem_written[i] = 1'b0;
      for (int i = 0; i < 9; i++) wreg[i] = 32'd0;
      upc_q = 9'd0;
      mbr_q = 8'd0;
      n_q = 1'b0;
      z_q = 1'b1;
      alu_last = 32'd0;
      b_last = 32'd0;
      build_stimulus();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // wait for the queues to drain, then let the core settle
      while (pending_items.size() > 0 || expected_states.size() > 0 || req_if.valid)
         @(posedge clock);
      repeat (40) @(posedge clock);
      $display("ran %0d steps, %0d control store loads, %0d memory loads, %0d byte reads",
               n_steps, n_cs_loads, n_mem_loads, n_reads);
      $display("%0d items sent, %0d results checked, %0d mismatches",
               sent_count, recv_count, failures);
      if (failures == 0 && expected_states.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
